>>> hw/rtl/rdi_pkg.sv
// ----------------------------------------------------------------------------
// rdi_pkg: ray / disk intersection shared definitions
// Widths, register indexes and the data carried from cell to cell.
// ----------------------------------------------------------------------------
package rdi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int QI_BITS   = 31 - FRAC_BITS;      // integer quotient bits
	localparam int Q_BITS    = 31;                  // non-negative t
	localparam int NUM_W     = 53;                  // dot product width
	localparam int STEPS     = QI_BITS + FRAC_BITS; // one quotient bit a cell

	localparam logic [2:0] REG_CENTER_X = 3'd0;
	localparam logic [2:0] REG_CENTER_Y = 3'd1;
	localparam logic [2:0] REG_CENTER_Z = 3'd2;
	localparam logic [2:0] REG_NORMAL_X = 3'd3;
	localparam logic [2:0] REG_NORMAL_Y = 3'd4;
	localparam logic [2:0] REG_NORMAL_Z = 3'd5;
	localparam logic [2:0] REG_RADIUS2  = 3'd6;
	localparam logic [2:0] REG_MIN_DIST = 3'd7;

	// Ray data and division state handed from one divider cell to the next.
	typedef struct packed {
		logic                    vld;
		logic                    miss;
		logic signed [31:0]      ox, oy, oz;
		logic signed [31:0]      dx, dy, dz;
		logic [NUM_W-1:0]        rem;   // partial remainder
		logic [NUM_W-1:0]        den;   // divisor magnitude
		logic [NUM_W-1:0]        an;    // dividend bits not yet consumed
		logic [Q_BITS-1:0]       q;
	} cell_t;

endpackage

>>> hw/rtl/ray_disk_intersection.sv
// ----------------------------------------------------------------------------
// ray_disk_intersection: fixed point ray / disk hit test
// Computes t = ((c - o) . n) / (d . n), the hit point and the radius test.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   origin_x..z, dir_x..z
//  out      out_valid / out_ready hit_flag, distance, hit_x..z
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One ray is taken per cycle unless the pipe stalls. The pipe is a product
// stage and a stage that sums the dot products and seeds the divider, a row
// of 31 division cells (the top bits of the dividend are checked against the
// divisor for overflow, then each cell yields one quotient bit, the last 16
// being fraction bits), then four stages for the hit point, squared distance
// and output register. The whole pipe advances together; it stalls only when
// the output register holds a result that is not taken. Reset clears every
// valid bit and loads the register reset values.
// ----------------------------------------------------------------------------
module ray_disk_intersection (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit_flag,
	output logic signed [31:0] distance,
	output logic signed [31:0] hit_x,
	output logic signed [31:0] hit_y,
	output logic signed [31:0] hit_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	localparam int NW = rdi_pkg::NUM_W;
	localparam int FB = rdi_pkg::FRAC_BITS;
	localparam int NS = rdi_pkg::STEPS;

	// Configuration registers.
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic signed [17:0] nx_q, ny_q, nz_q;
	logic [31:0]        r2_q;
	logic [30:0]        mind_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0; cy_q <= '0; cz_q <= '0;
			nx_q <= '0; ny_q <= '0; nz_q <= 18'sd65536;
			r2_q <= 32'd65536;
			mind_q <= 31'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				rdi_pkg::REG_CENTER_X: cx_q <= cfg_data;
				rdi_pkg::REG_CENTER_Y: cy_q <= cfg_data;
				rdi_pkg::REG_CENTER_Z: cz_q <= cfg_data;
				rdi_pkg::REG_NORMAL_X: nx_q <= cfg_data[17:0];
				rdi_pkg::REG_NORMAL_Y: ny_q <= cfg_data[17:0];
				rdi_pkg::REG_NORMAL_Z: nz_q <= cfg_data[17:0];
				rdi_pkg::REG_RADIUS2:  r2_q <= cfg_data;
				rdi_pkg::REG_MIN_DIST: mind_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// The whole pipe moves when the output register is free or being drained.
	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// Stage 1: component products (33 x 18 bits for the center terms, 32 x 18 for the direction terms).
	logic              v_s1;
	logic signed [50:0] pnx_s1, pny_s1, pnz_s1, pdx_s1, pdy_s1, pdz_s1;
	logic signed [31:0] ox_s1, oy_s1, oz_s1, dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pnx_s1 <= (33'(cx_q) - 33'(origin_x)) * nx_q;
			pny_s1 <= (33'(cy_q) - 33'(origin_y)) * ny_q;
			pnz_s1 <= (33'(cz_q) - 33'(origin_z)) * nz_q;
			pdx_s1 <= 51'(dir_x) * nx_q;
			pdy_s1 <= 51'(dir_y) * ny_q;
			pdz_s1 <= 51'(dir_z) * nz_q;
			ox_s1 <= origin_x; oy_s1 <= origin_y; oz_s1 <= origin_z;
			dx_s1 <= dir_x; dy_s1 <= dir_y; dz_s1 <= dir_z;
		end
	end

	// Stage 2: sums, signs and magnitudes seed the first division cell.
	logic signed [NW-1:0] num, den;
	logic [NW-1:0]        anm, adm;
	rdi_pkg::cell_t chain [NS+1];

	always_comb begin
		num = NW'(pnx_s1) + NW'(pny_s1) + NW'(pnz_s1);
		den = NW'(pdx_s1) + NW'(pdy_s1) + NW'(pdz_s1);
	end

	assign anm = num[NW-1] ? NW'(-num) : num;
	assign adm = den[NW-1] ? NW'(-den) : den;

	logic neg_s2_in;
	assign neg_s2_in = num[NW-1] != den[NW-1];

	// The quotient is (an * 2^FRAC_BITS) / ad. Its bits above the 31 kept ones
	// are all zero exactly when an >> QI_BITS is below ad, so the row starts
	// with that as the partial remainder and shifts in the low QI_BITS bits of
	// an followed by FRAC_BITS zeros.
	// A wrong sign with a nonzero quotient misses; a zero quotient does not.
	// So the sign travels in the miss bit only once t is known to be nonzero;
	// here it is kept aside in a side pipe below.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0] <= '0;
		end else if (adv) begin
			chain[0].vld <= v_s1;
			chain[0].miss <= (den == '0);
			chain[0].ox <= ox_s1; chain[0].oy <= oy_s1; chain[0].oz <= oz_s1;
			chain[0].dx <= dx_s1; chain[0].dy <= dy_s1; chain[0].dz <= dz_s1;
			chain[0].rem <= anm >> rdi_pkg::QI_BITS;
			chain[0].den <= adm;
			chain[0].an <= {anm[rdi_pkg::QI_BITS-1:0], {(NW - rdi_pkg::QI_BITS){1'b0}}};
			chain[0].q <= '0;
		end
	end

	// Sign of t travels beside the division row.
	logic neg_sr [NS+1];
	always_ff @(posedge clk) begin
		if (adv) neg_sr[0] <= neg_s2_in;
	end

	// Integer-quotient overflow flag, set when the starting partial remainder
	// is not below the divisor.
	logic ovf_sr [NS+1];
	always_ff @(posedge clk) begin
		if (adv) ovf_sr[0] <= 1'b0;
	end

	// Row of cells: the first QI_BITS cells give the integer bits of t and the
	// last FRAC_BITS cells its fraction bits. The first cell also makes the
	// overflow test on the seed it receives.
	genvar g;
	generate
		for (g = 0; g < NS; g++) begin : g_cell
			rdi_div_cell u_cell (
				.clk(clk), .arst_n(arst_n), .en(adv),
				.din(chain[g]), .dout(chain[g+1])
			);
			always_ff @(posedge clk) begin
				if (adv) begin
					neg_sr[g+1] <= neg_sr[g];
					ovf_sr[g+1] <= ovf_sr[g] |
						((g == 0) && (chain[g].rem >= chain[g].den));
				end
			end
		end
	endgenerate

	// Tail stage A: t checks and d * t products.
	rdi_pkg::cell_t tl;
	logic [30:0] q_t;
	logic        bad_t;
	assign tl = chain[NS];
	assign q_t = tl.q;

	always_comb begin
		bad_t = tl.miss || ovf_sr[NS] ||
			(neg_sr[NS] && q_t != '0) || (q_t < mind_q);
	end

	logic               v_a, miss_a;
	logic [30:0]        t_a;
	logic signed [63:0] mx_a, my_a, mz_a;
	logic signed [31:0] ox_a, oy_a, oz_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_a <= 1'b0;
		else if (adv) v_a <= tl.vld;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_a <= bad_t;
			t_a <= q_t;
			mx_a <= tl.dx * $signed({1'b0, q_t});
			my_a <= tl.dy * $signed({1'b0, q_t});
			mz_a <= tl.dz * $signed({1'b0, q_t});
			ox_a <= tl.ox; oy_a <= tl.oy; oz_a <= tl.oz;
		end
	end

	// Tail stage B: hit point and offset from the center.
	logic               v_b, miss_b;
	logic [30:0]        t_b;
	logic signed [48:0] px_b, py_b, pz_b;
	logic signed [49:0] ex_b, ey_b, ez_b;
	logic signed [48:0] px_n, py_n, pz_n;

	always_comb begin
		px_n = 49'(ox_a) + 49'(mx_a >>> FB);
		py_n = 49'(oy_a) + 49'(my_a >>> FB);
		pz_n = 49'(oz_a) + 49'(mz_a >>> FB);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_b <= 1'b0;
		else if (adv) v_b <= v_a;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_b <= miss_a;
			t_b <= t_a;
			px_b <= px_n; py_b <= py_n; pz_b <= pz_n;
			ex_b <= 50'(cx_q) - 50'(px_n);
			ey_b <= 50'(cy_q) - 50'(py_n);
			ez_b <= 50'(cz_q) - 50'(pz_n);
		end
	end

	// Tail stage C: magnitudes, far test, squares.
	logic [49:0] ux, uy, uz;
	assign ux = ex_b[49] ? 50'(-ex_b) : 50'(ex_b);
	assign uy = ey_b[49] ? 50'(-ey_b) : 50'(ey_b);
	assign uz = ez_b[49] ? 50'(-ez_b) : 50'(ez_b);

	logic               v_c, miss_c;
	logic [30:0]        t_c;
	logic signed [48:0] px_c, py_c, pz_c;
	logic [57:0]        sx_c, sy_c, sz_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_c <= 1'b0;
		else if (adv) v_c <= v_b;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			miss_c <= miss_b || (ux[49:29] != '0) || (uy[49:29] != '0) ||
				(uz[49:29] != '0);
			t_c <= t_b;
			px_c <= px_b; py_c <= py_b; pz_c <= pz_b;
			sx_c <= 58'(ux[28:0]) * 58'(ux[28:0]);
			sy_c <= 58'(uy[28:0]) * 58'(uy[28:0]);
			sz_c <= 58'(uz[28:0]) * 58'(uz[28:0]);
		end
	end

	// Tail stage D / output register: radius test and saturation.
	logic [59:0] d2;
	logic        hit_n;
	assign d2 = 60'(sx_c) + 60'(sy_c) + 60'(sz_c);
	assign hit_n = !miss_c && (d2 < (60'(r2_q) << FB));

	function automatic logic [31:0] sat32(input logic signed [48:0] v);
		if (v > 49'sd2147483647) return 32'h7FFFFFFF;
		if (v < -49'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_flag <= hit_n;
			distance <= hit_n ? {1'b0, t_c} : '0;
			hit_x <= hit_n ? sat32(px_c) : '0;
			hit_y <= hit_n ? sat32(py_c) : '0;
			hit_z <= hit_n ? sat32(pz_c) : '0;
		end
	end
endmodule

>>> hw/rtl/rdi_div_cell.sv
// ----------------------------------------------------------------------------
// rdi_div_cell: one restoring division step
// Brings in one dividend bit (or a zero for fraction bits), trial subtracts,
// and passes the ray on to its neighbor.
// ----------------------------------------------------------------------------
module rdi_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  rdi_pkg::cell_t  din,
	output rdi_pkg::cell_t  dout
);
	rdi_pkg::cell_t nxt;
	logic [rdi_pkg::NUM_W:0] sh;
	logic [rdi_pkg::NUM_W:0] diff;

	always_comb begin
		nxt = din;
		sh = {din.rem, din.an[rdi_pkg::NUM_W-1]};
		diff = sh - {1'b0, din.den};
		nxt.an = {din.an[rdi_pkg::NUM_W-2:0], 1'b0};
		if (!diff[rdi_pkg::NUM_W]) begin
			nxt.rem = diff[rdi_pkg::NUM_W-1:0];
			nxt.q = {din.q[rdi_pkg::Q_BITS-2:0], 1'b1};
		end else begin
			nxt.rem = sh[rdi_pkg::NUM_W-1:0];
			nxt.q = {din.q[rdi_pkg::Q_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end
endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: ray / disk intersection testbench
// Streams rays through the block under several disk settings, predicts each
// result in the bench and compares every output transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int LIMIT_CYCLES = 300000;
	localparam int DRAIN_CYCLES = 70;    // comfortably more than the pipe is deep

	typedef struct {
		logic signed [31:0] ox, oy, oz;
		logic signed [31:0] dx, dy, dz;
	} ray_t;

	typedef struct {
		logic               hit;
		logic signed [31:0] tval;
		logic signed [31:0] hx, hy, hz;
	} disk_hit_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               hit_flag;
	logic signed [31:0] distance, hit_x, hit_y, hit_z;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	// Bench copy of the disk registers, updated on each register transfer.
	longint ctr_x, ctr_y, ctr_z, nrm_x, nrm_y, nrm_z, rad2, min_t;

	ray_t      ray_queue[$];
	disk_hit_t hit_queue[$];
	int        rays_issued = 0;
	int        rays_taken  = 0;
	int        errors      = 0;
	int        cycles      = 0;
	int        send_gap    = 0;
	int        recv_stall  = 0;
	int        hold_cnt    = 0;
	logic      hold_go     = 1'b0;
	logic      quiet       = 1'b0;

	ray_disk_intersection dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit_flag(hit_flag), .distance(distance),
		.hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// Intersect one ray with the disk held in the bench registers.
	function automatic disk_hit_t trace_ray(ray_t r);
		longint ox, oy, oz, dx, dy, dz, num, den, t, px, py, pz;
		longint unsigned an, ad, qi, rem, frac, q, ux, uy, uz, d2;
		logic neg;
		disk_hit_t res;
		res = '{hit: 1'b0, tval: '0, hx: '0, hy: '0, hz: '0};
		ox = r.ox; oy = r.oy; oz = r.oz;
		dx = r.dx; dy = r.dy; dz = r.dz;
		num = (ctr_x - ox) * nrm_x + (ctr_y - oy) * nrm_y + (ctr_z - oz) * nrm_z;
		den = dx * nrm_x + dy * nrm_y + dz * nrm_z;
		// A ray parallel to the plane never meets it.
		if (den == 0)
			return res;
		neg = (num < 0) != (den < 0);
		an = magnitude(num);
		ad = magnitude(den);
		qi = an / ad;
		rem = an % ad;
		if (qi > (64'h7FFFFFFF >> rdi_pkg::FRAC_BITS))
			return res;
		// Long division for the fraction bits, truncated toward zero.
		frac = 0;
		for (int i = 0; i < rdi_pkg::FRAC_BITS; i++) begin
			rem = rem << 1;
			frac = frac << 1;
			if (rem >= ad) begin
				rem = rem - ad;
				frac = frac | 1;
			end
		end
		q = (qi << rdi_pkg::FRAC_BITS) | frac;
		if (neg && q != 0)
			return res;
		if (q > 64'h7FFFFFFF || q < min_t)
			return res;
		t = q;
		// Arithmetic shift rounds the scaled step toward minus infinity.
		px = ox + ((dx * t) >>> rdi_pkg::FRAC_BITS);
		py = oy + ((dy * t) >>> rdi_pkg::FRAC_BITS);
		pz = oz + ((dz * t) >>> rdi_pkg::FRAC_BITS);
		ux = magnitude(ctr_x - px);
		uy = magnitude(ctr_y - py);
		uz = magnitude(ctr_z - pz);
		if (ux >= (64'd1 << 29) || uy >= (64'd1 << 29) || uz >= (64'd1 << 29))
			return res;
		d2 = ux * ux + uy * uy + uz * uz;
		if (d2 >= (longint'(rad2) << rdi_pkg::FRAC_BITS))
			return res;
		res.hit  = 1'b1;
		res.tval = q[31:0];
		res.hx   = clamp32(px);
		res.hy   = clamp32(py);
		res.hz   = clamp32(pz);
		return res;
	endfunction

	// Sender: takes rays from the queue, with random gaps between transfers.
	always @(posedge clk or negedge arst_n) begin
		ray_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				r = '{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z};
				hit_queue.push_back(trace_ray(r));
				rays_taken <= rays_taken + 1;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0 && !quiet) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (ray_queue.size() > 0) begin
					r = ray_queue.pop_front();
					origin_x <= r.ox; origin_y <= r.oy; origin_z <= r.oz;
					dir_x <= r.dx; dir_y <= r.dy; dir_z <= r.dz;
					in_valid <= 1'b1;
					if ($urandom_range(0, 11) == 0)
						send_gap <= $urandom_range(1, 14);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// The long receiver hold-off is counted here, apart from the random stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_cnt <= 0;
		else if (hold_go)
			hold_cnt <= 400;
		else if (hold_cnt > 0)
			hold_cnt <= hold_cnt - 1;
	end

	function automatic void report(string name, logic signed [31:0] want,
			logic signed [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Receiver: checks every result transfer against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		disk_hit_t want;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (hit_queue.size() == 0) begin
					$display("%0t: result transfer with no prediction waiting", $time);
					errors++;
				end else begin
					want = hit_queue.pop_front();
					report("hit_flag", want.hit, hit_flag);
					report("distance", want.tval, distance);
					report("hit_x", want.hx, hit_x);
					report("hit_y", want.hy, hit_y);
					report("hit_z", want.hz, hit_z);
				end
			end
			if (hold_go || hold_cnt > 1) begin
				out_ready <= 1'b0;
			end else if (quiet) begin
				out_ready <= 1'b1;
			end else if (recv_stall > 0) begin
				recv_stall <= recv_stall - 1;
				out_ready  <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if ($urandom_range(0, 9) == 0)
					recv_stall <= $urandom_range(1, 14);
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Called at a rising edge; leaves cfg_valid high for a following write.
	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			rdi_pkg::REG_CENTER_X: ctr_x = longint'($signed(val));
			rdi_pkg::REG_CENTER_Y: ctr_y = longint'($signed(val));
			rdi_pkg::REG_CENTER_Z: ctr_z = longint'($signed(val));
			rdi_pkg::REG_NORMAL_X: nrm_x = longint'($signed(val[17:0]));
			rdi_pkg::REG_NORMAL_Y: nrm_y = longint'($signed(val[17:0]));
			rdi_pkg::REG_NORMAL_Z: nrm_z = longint'($signed(val[17:0]));
			rdi_pkg::REG_RADIUS2:  rad2  = val;
			rdi_pkg::REG_MIN_DIST: min_t = val[30:0];
			default: ;
		endcase
	endtask

	task automatic program_disk(longint cx, cy, cz, nx, ny, nz, r2, md);
		write_reg(rdi_pkg::REG_CENTER_X, cx[31:0]);
		write_reg(rdi_pkg::REG_CENTER_Y, cy[31:0]);
		write_reg(rdi_pkg::REG_CENTER_Z, cz[31:0]);
		write_reg(rdi_pkg::REG_NORMAL_X, nx[31:0]);
		write_reg(rdi_pkg::REG_NORMAL_Y, ny[31:0]);
		write_reg(rdi_pkg::REG_NORMAL_Z, nz[31:0]);
		write_reg(rdi_pkg::REG_RADIUS2, r2[31:0]);
		write_reg(rdi_pkg::REG_MIN_DIST, md[31:0]);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_ray(longint ox, oy, oz, dx, dy, dz);
		ray_t r;
		r = '{ox[31:0], oy[31:0], oz[31:0], dx[31:0], dy[31:0], dz[31:0]};
		ray_queue.push_back(r);
		rays_issued++;
	endtask

	function automatic longint spread(int span);
		return longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Mostly rays aimed close to the disk center so that hits are common;
	// the rest are rays with every bit random.
	task automatic send_mix(int n);
		longint tx, ty, tz, ox, oy, oz;
		int reach;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				send_ray($signed($urandom), $signed($urandom), $signed($urandom),
					$signed($urandom), $signed($urandom), $signed($urandom));
			end else begin
				reach = 1 << $urandom_range(12, 22);
				tx = ctr_x + spread(1 << 17);
				ty = ctr_y + spread(1 << 17);
				tz = ctr_z + spread(1 << 17);
				ox = tx + spread(reach);
				oy = ty + spread(reach);
				oz = tz + spread(reach);
				send_ray(ox, oy, oz, tx - ox, ty - oy, tz - oz);
			end
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (rays_taken != rays_issued || hit_queue.size() != 0);
	endtask

	initial begin
		ctr_x = 0; ctr_y = 0; ctr_z = 0;
		nrm_x = 0; nrm_y = 0; nrm_z = 65536;
		rad2 = 65536; min_t = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rays against the reset disk: unit disk at the origin, facing +z.
		send_ray(0, 0, 65536, 0, 0, -65536);            // straight hit at t = 1
		send_ray(0, 0, 131072, 0, 0, -65536);           // hit at t = 2
		send_ray(32768, -32768, 65536, 0, 0, -65536);   // hit off center
		send_ray(65536, 0, 65536, 0, 0, -65536);        // on the rim, outside
		send_ray(0, 0, 65536, 65536, 0, 0);             // parallel to the plane
		send_ray(0, 0, 65536, 0, 0, 65536);             // pointing away
		send_ray(0, 0, 0, 0, 0, 65536);                 // starts on the plane, t = 0
		send_ray(0, 0, 1, 0, 0, -65536);                // t of one LSB
		send_ray(0, 0, 32'h7FFFFFFF, 0, 0, -1);         // t overflows
		send_ray(0, 0, 65536, 0, 0, -3);                // large t that still fits
		send_ray(0, 0, 65536, 0, 0, -196608);           // t with a repeating fraction
		send_ray(-7, 3, 65536, -5, 9, -65535);          // negative floor rounding
		send_ray(0, 0, 65536, 32'h7FFFFFFF, 0, -65536); // far hit point
		send_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
			-64'sd2147483648, -64'sd2147483648, -64'sd2147483648);
		send_ray(-64'sd2147483648, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, -64'sd2147483648, -1);
		send_ray(0, 0, 0, 0, 0, 0);
		send_ray(-1, -1, -1, -1, -1, -1);
		wait_drained();

		// Small disk near the origin, zero minimum distance, zero radius.
		program_disk(spread(1 << 20), spread(1 << 20), spread(1 << 20),
			-65536, 0, 0, 0, 0);
		send_ray(ctr_x + 65536, ctr_y, ctr_z, -65536, 0, 0);
		send_mix(100);
		wait_drained();

		// Tilted, unnormalized normal at the extremes of its width; huge radius.
		program_disk(spread(1 << 22), spread(1 << 22), spread(1 << 22),
			32'h1FFFF, 32'h20000, 65536, 32'hFFFFFFFF, 1);
		send_mix(120);
		wait_drained();

		// Center at the edges of the range, so hit points saturate.
		program_disk(32'h7FFFFFFF, 32'h80000000, 0, 0, 65536, 0, 32'hFFFFFFFF, 0);
		send_mix(110);
		wait_drained();

		// Largest minimum distance: nearly everything misses.
		program_disk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, 32'h7FFFFFFF);
		send_mix(40);
		wait_drained();

		// Receiver holds off while the sender keeps offering, filling the pipe.
		program_disk(spread(1 << 20), spread(1 << 20), spread(1 << 20),
			0, 0, -65536, 4 << 16, 1);
		send_mix(160);
		@(posedge clk);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		wait_drained();

		// Every register with random bits.
		program_disk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom);
		send_mix(120);
		wait_drained();
		program_disk(spread(1 << 24), spread(1 << 24), spread(1 << 24),
			spread(65536), spread(65536), spread(65536), $urandom_range(0, 1 << 22),
			$urandom_range(0, 1 << 14));
		send_mix(100);
		wait_drained();

		// Last part at full rate with no idling on either side.
		quiet <= 1'b1;
		program_disk(spread(1 << 20), spread(1 << 20), spread(1 << 20),
			0, 0, 65536, 2 << 16, $urandom_range(0, 1 << 15));
		send_mix(100);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && hit_queue.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
